// ===== rtl/dxtd_pkg.sv =====
// dxtd_pkg: shared types, mode codes and small arithmetic helpers for the
// dxt texture block decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dxtd_pkg;

  // block format codes held in the mode register
  localparam logic [1:0] MODE_DXT1 = 2'd0;
  localparam logic [1:0] MODE_DXT3 = 2'd1;
  localparam logic [1:0] MODE_DXT5 = 2'd2;

  localparam logic [3:0] LAST_PIXEL = 4'd15;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // one compressed block
  typedef struct packed {
    logic [63:0] alpha_block;
    logic [63:0] color_block;
  } in_beat_t;

  // one decoded pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [3:0] pixel_index;
    logic       last;
  } out_beat_t;

  // decoded palettes of one block, handed to the pixel serializer
  typedef struct packed {
    logic [1:0]            mode;
    logic                  four;
    logic [3:0][2:0][7:0]  pal;    // entry, channel r/g/b
    logic [7:0][7:0]       av;     // dxt5 alpha palette
    logic [31:0]           cidx;   // 2-bit color index per pixel
    logic [63:0]           ablk;   // raw alpha bits
  } dxtd_blk_t;

  // 565 widening by bit replication
  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // floor(x / 3) for x <= 765 by reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'd683;
    return p[18:11];
  endfunction

  // floor(x / 7) for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

  // floor(x / 5) for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd3277;
    return p[21:14];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dxtd_palette.sv =====
// dxtd_palette: three-stage pipeline that builds the color and alpha
// palettes of one block. Depends on dxtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dxtd_palette import dxtd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] mode,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_beat_t   in_data,
  output logic            blk_valid,
  input  wire logic       blk_ready,
  output dxtd_blk_t       blk
);

  // stage valids and ready chain
  logic v0, v1, v2;
  logic rdy0, rdy1, rdy2;

  assign rdy2     = !v2 || blk_ready;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_stall = !rdy0;
  assign blk_valid = v2;

  // stage 0: input capture
  in_beat_t   d0;
  logic [1:0] m0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= in_valid;
    end
    if (rdy0 && in_valid) begin
      d0 <= in_data;
      m0 <= mode;
    end
  end

  // stage a: endpoint widening, color sums, alpha numerators
  logic [15:0]          e0, e1;
  logic [2:0][7:0]      c0_a, c1_a;
  logic [2:0][9:0]      s2_a, s3_a;
  logic [5:0][10:0]     num_a;
  logic [7:0]           a0_a, a1_a;
  logic                 gt_a, four_a;

  always_comb begin
    e0 = d0.color_block[15:0];
    e1 = d0.color_block[31:16];
    c0_a[0] = expand5(e0[15:11]);
    c0_a[1] = expand6(e0[10:5]);
    c0_a[2] = expand5(e0[4:0]);
    c1_a[0] = expand5(e1[15:11]);
    c1_a[1] = expand6(e1[10:5]);
    c1_a[2] = expand5(e1[4:0]);
    four_a = (m0 == MODE_DXT3) || (m0 == MODE_DXT5) || (e0 > e1);
    for (int ch = 0; ch < 3; ch++) begin
      if (four_a) begin
        s2_a[ch] = {1'b0, c0_a[ch], 1'b0} + {2'b00, c1_a[ch]};
        s3_a[ch] = {2'b00, c0_a[ch]} + {1'b0, c1_a[ch], 1'b0};
      end else begin
        s2_a[ch] = {2'b00, c0_a[ch]} + {2'b00, c1_a[ch]};
        s3_a[ch] = 10'd0;
      end
    end
    a0_a = d0.alpha_block[7:0];
    a1_a = d0.alpha_block[15:8];
    gt_a = a0_a > a1_a;
    // inner alpha weights, k = 1..6
    for (int k = 1; k <= 6; k++) begin
      if (gt_a) begin
        num_a[k-1] = {3'd0, a0_a} * 11'(7 - k) + {3'd0, a1_a} * 11'(k);
      end else if (k <= 4) begin
        num_a[k-1] = {3'd0, a0_a} * 11'(5 - k) + {3'd0, a1_a} * 11'(k);
      end else begin
        num_a[k-1] = 11'd0;
      end
    end
  end

  logic [2:0][7:0]  c0_1, c1_1;
  logic [2:0][9:0]  s2_1, s3_1;
  logic [5:0][10:0] num_1;
  logic [7:0]       a0_1, a1_1;
  logic             gt_1, four_1;
  logic [1:0]       m1;
  logic [31:0]      cidx_1;
  logic [63:0]      ablk_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
    if (rdy1 && v0) begin
      c0_1   <= c0_a;
      c1_1   <= c1_a;
      s2_1   <= s2_a;
      s3_1   <= s3_a;
      num_1  <= num_a;
      a0_1   <= a0_a;
      a1_1   <= a1_a;
      gt_1   <= gt_a;
      four_1 <= four_a;
      m1     <= m0;
      cidx_1 <= d0.color_block[63:32];
      ablk_1 <= d0.alpha_block;
    end
  end

  // stage b: constant divisions into palette entries
  dxtd_blk_t blk_b;

  always_comb begin
    blk_b.mode = m1;
    blk_b.four = four_1;
    blk_b.cidx = cidx_1;
    blk_b.ablk = ablk_1;
    for (int ch = 0; ch < 3; ch++) begin
      blk_b.pal[0][ch] = c0_1[ch];
      blk_b.pal[1][ch] = c1_1[ch];
      blk_b.pal[2][ch] = four_1 ? div3(s2_1[ch]) : s2_1[ch][8:1];
      blk_b.pal[3][ch] = four_1 ? div3(s3_1[ch]) : 8'd0;
    end
    blk_b.av[0] = a0_1;
    blk_b.av[1] = a1_1;
    for (int k = 1; k <= 6; k++) begin
      if (gt_1) begin
        blk_b.av[k+1] = div7(num_1[k-1]);
      end else if (k <= 4) begin
        blk_b.av[k+1] = div5(num_1[k-1]);
      end else if (k == 5) begin
        blk_b.av[k+1] = 8'd0;
      end else begin
        blk_b.av[k+1] = ALPHA_OPAQUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      blk <= blk_b;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dxtd_serializer.sv =====
// dxtd_serializer: holds one decoded block and emits its sixteen pixels,
// one per cycle while out_stall is low, through an output register. Depends on dxtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dxtd_serializer import dxtd_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      blk_valid,
  output logic           blk_ready,
  input  wire dxtd_blk_t blk,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data
);

  logic      busy;
  logic [3:0] cnt;
  dxtd_blk_t cur;
  logic      adv, emit, done;

  assign adv       = !out_valid || !out_stall;
  assign emit      = busy && adv;
  assign done      = emit && (cnt == LAST_PIXEL);
  assign blk_ready = !busy || done;

  // pixel selection from the held palettes
  logic [1:0] ci;
  out_beat_t  pix;

  always_comb begin
    ci = cur.cidx[1:0];
    pix.red         = cur.pal[ci][0];
    pix.green       = cur.pal[ci][1];
    pix.blue        = cur.pal[ci][2];
    pix.pixel_index = cnt;
    pix.last        = (cnt == LAST_PIXEL);
    case (cur.mode)
      MODE_DXT3: pix.alpha = {cur.ablk[3:0], cur.ablk[3:0]};
      MODE_DXT5: pix.alpha = cur.av[cur.ablk[18:16]];
      default:   pix.alpha = (!cur.four && ci == 2'd3) ? 8'd0 : ALPHA_OPAQUE;
    endcase
  end

  // block hold, pixel counter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (blk_ready) begin
        busy <= blk_valid;
      end
      if (blk_ready && blk_valid) begin
        cnt <= 4'd0;
      end else if (emit) begin
        cnt <= cnt + 4'd1;
      end
    end
    if (blk_ready && blk_valid) begin
      cur <= blk;
    end else if (emit) begin
      cur.cidx <= cur.cidx >> 2;
      cur.ablk <= (cur.mode == MODE_DXT3) ? (cur.ablk >> 4) : (cur.ablk >> 3);
    end
    if (emit) begin
      out_data <= pix;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dxt_texture_block_decoder_core.sv =====
// path: a block beat passes the palette stages and the serializer's block hold before
// its first pixel is registered on out_data; the other fifteen follow one per cycle when
// out_stall is low; the block rate is set by the single pixel output port
// reset (rst, synchronous): clears all valid bits and the pixel counter, mode to dxt1
// dxt_texture_block_decoder_core: mode register, palette pipeline and serializer.
// Depends on dxtd_pkg, dxtd_palette, dxtd_serializer.
`timescale 1ns / 1ps
`default_nettype none

module dxt_texture_block_decoder_core import dxtd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_beat_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_beat_t       out_data
);

  // mode register
  logic [1:0] mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DXT1;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  logic      blk_valid, blk_ready;
  dxtd_blk_t blk;

  dxtd_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk)
  );

  dxtd_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/dxtd_checker.sv =====
// dxtd_checker: port-level assertions on the decoder output stream, bound to
// the top level. Depends on dxtd_pkg and dxt_texture_block_decoder_core.
`timescale 1ns / 1ps
`default_nettype none

module dxtd_checker import dxtd_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       cfg_we,
  input wire logic [1:0] cfg_wdata,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire out_beat_t  out_data
);

  // shadow of the mode register
  logic [1:0] mode_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_seen <= MODE_DXT1;
    end else if (cfg_we) begin
      mode_seen <= cfg_wdata;
    end
  end

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");

  // last flag marks pixel fifteen only
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == (out_data.pixel_index == LAST_PIXEL)))
    else $error("last flag and pixel index disagree");

  // pixels of a block come back to back in raster order
  a_pixel_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.last |=>
      out_valid && out_data.pixel_index == $past(out_data.pixel_index) + 4'd1)
    else $error("pixel sequence broken inside a block");

  // dxt1 alpha is opaque, or transparent black
  a_dxt1_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_seen != MODE_DXT3 && mode_seen != MODE_DXT5 |->
      out_data.alpha == ALPHA_OPAQUE ||
      (out_data.alpha == 8'd0 && out_data.red == 8'd0 &&
       out_data.green == 8'd0 && out_data.blue == 8'd0))
    else $error("dxt1 pixel with partial alpha");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind dxt_texture_block_decoder_core dxtd_checker u_dxtd_checker (.*);

`default_nettype wire
